FILE: rtl/core/integer_sorter_top_defines.svh
// ---------------------------------------------------------------------------
// integer_sorter_top_defines
// Assertion macros shared by the sorter checker.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SORTER_TOP_DEFINES_SVH
`define INTEGER_SORTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ISORT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/isort_pkg.sv
// ---------------------------------------------------------------------------
// isort_pkg
// Types and constants shared by the insertion sorter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;
		logic emit;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/isort_cell.sv
// ---------------------------------------------------------------------------
// isort_cell
// One slot of the sorting chain: holds a value, opens a gap for a smaller
// new item by taking its left neighbor, and shifts left during readout.
// ---------------------------------------------------------------------------
`default_nettype none

module isort_cell
	import isort_pkg::*;
#(
	parameter bit FIRST = 1'b0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire data_t      new_val,
	input  wire data_t      left_val,
	input  wire logic       left_vld,
	input  wire logic       left_lt,
	input  wire data_t      right_val,
	input  wire logic       right_vld,
	output data_t           val,
	output logic            vld,
	output logic            lt
);

	data_t val_q;
	logic  vld_q;
	logic  take_new;

	assign lt       = !vld_q || (new_val < val_q);
	assign take_new = FIRST || !left_lt;
	assign val      = val_q;
	assign vld      = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.emit) begin
			vld_q <= right_vld;
		end else if (ctrl.insert && lt) begin
			vld_q <= take_new ? 1'b1 : left_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			val_q <= right_val;
		end else if (ctrl.insert && lt) begin
			val_q <= take_new ? new_val : left_val;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/integer_sorter_top.sv
// ---------------------------------------------------------------------------
// integer_sorter_top
// Insertion sorter for signed 32-bit items built as a row of MAX_ITEMS cells.
// Load: one item per cycle while not busy, placed in order in the same cycle
// (dropped, setting overflow, if the row is full). Readout: first result the
// cycle after the last item is taken, then one result per cycle from the head
// cell, busy high. Reset clears all valid bits, count and drop flag at once.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_sorter_top
	import isort_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] value,
	input  wire logic        last,
	output logic             strobe,
	output logic [31:0]      sorted_value,
	output logic             final_res,
	output logic             overflow
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             accept;
	logic             full;
	cell_ctrl_t       ctrl;
	data_t            new_val;

	data_t cell_val   [MAX_ITEMS];
	logic  cell_vld   [MAX_ITEMS];
	logic  cell_lt    [MAX_ITEMS];
	data_t left_val   [MAX_ITEMS];
	logic  left_vld   [MAX_ITEMS];
	logic  left_lt    [MAX_ITEMS];
	data_t right_val  [MAX_ITEMS];
	logic  right_vld  [MAX_ITEMS];

	assign new_val = data_t'(value);
	assign full    = (count_q == CNT_W'(MAX_ITEMS));
	assign accept  = start && (state_q == ST_LOAD);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: if (accept && last) state_nxt = ST_EMIT;
			ST_EMIT: if (count_q == CNT_W'(1)) state_nxt = ST_LOAD;
			default: state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		strobe      = 1'b0;
		ctrl.insert = 1'b0;
		ctrl.emit   = 1'b0;
		unique case (state_q)
			ST_LOAD: ctrl.insert = accept && !full;
			ST_EMIT: begin
				busy      = 1'b1;
				strobe    = 1'b1;
				ctrl.emit = 1'b1;
			end
			default: ;
		endcase
	end

	assign sorted_value = 32'(cell_val[0]);
	assign final_res    = strobe && (count_q == CNT_W'(1));
	assign overflow     = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.emit) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept && full) begin
				dropped_q <= 1'b1;
			end else if (ctrl.emit && count_q == CNT_W'(1)) begin
				dropped_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_val[i] = '0;
			assign left_vld[i] = 1'b0;
			assign left_lt[i]  = 1'b0;
		end else begin : g_body
			assign left_val[i] = cell_val[i-1];
			assign left_vld[i] = cell_vld[i-1];
			assign left_lt[i]  = cell_lt[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_val[i] = '0;
			assign right_vld[i] = 1'b0;
		end else begin : g_inner
			assign right_val[i] = cell_val[i+1];
			assign right_vld[i] = cell_vld[i+1];
		end

		isort_cell #(
			.FIRST (i == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_val   (new_val),
			.left_val  (left_val[i]),
			.left_vld  (left_vld[i]),
			.left_lt   (left_lt[i]),
			.right_val (right_val[i]),
			.right_vld (right_vld[i]),
			.val       (cell_val[i]),
			.vld       (cell_vld[i]),
			.lt        (cell_lt[i])
		);
	end

endmodule

`default_nettype wire

FILE: rtl/core/isort_checker.sv
// ---------------------------------------------------------------------------
// isort_checker
// Port-level checks on the sorter readout sequence, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "integer_sorter_top_defines.svh"

module isort_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        strobe,
	input wire logic        final_res,
	input wire logic        overflow
);

	`ISORT_ASSERT_IMPL(a_strobe_busy, strobe, busy, "result outside readout")
	`ISORT_ASSERT_IMPL(a_final_strobe, final_res, strobe, "final mark without result")
	`ISORT_ASSERT_NEXT(a_final_ends, strobe && final_res, !strobe, "readout runs past final")
	`ISORT_ASSERT_NEXT(a_run_holds, strobe && !final_res, strobe, "readout gap before final")
	`ISORT_ASSERT_NEXT(a_ovf_stable, strobe && !final_res, $stable(overflow), "overflow unstable")

endmodule

bind integer_sorter_top isort_checker u_isort_checker (.*);

`default_nettype wire

FILE: tb/tb_integer_sorter_top.sv
// ---------------------------------------------------------------------------
// tb_integer_sorter_top
// Self-checking bench for the insertion sorter. Sends sets of signed items
// through the start/busy handshake with random gaps, predicts each result
// from its sorted-insert store or a typed row, and checks each strobed result
// in order. A directed table covers extremes, duplicates, a full store and
// dropped items; random sets of mixed size and value spread follow.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_integer_sorter_top
	import isort_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITEMS = 64;
	localparam int RANDOM_ITEMS = 74;
	localparam int DIR_ROWS_N = 22;

	typedef struct packed {
		data_t val;
		logic  fin;
		logic  ovf;
	} sorted_t;

	typedef struct packed {
		data_t      value;
		logic       last;
		logic [7:0] fill;
		logic       typed;
		logic       exp_ovf;
	} dir_row_t;

	typedef enum int {
		VAL_WIDE,
		VAL_CLUSTER,
		VAL_EDGE
	} val_style_t;

	// value, last, leading fill items, typed expectation, expected overflow
	localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
		'{32'h0000_0000, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'h8000_0000, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'h0000_0001, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'h5555_5555, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'hAAAA_AAAA, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h8000_0000, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0000, 1'b1, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0007, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'hFFFF_FFF9, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0007, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0007, 1'b1, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0003, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0002, 1'b0, 8'd0,  1'b0, 1'b0},
		'{32'h0000_0001, 1'b1, 8'd0,  1'b0, 1'b0},
		'{32'h8000_0000, 1'b1, 8'd0,  1'b0, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 8'd64, 1'b0, 1'b0},
		'{32'h0000_002A, 1'b1, 8'd0,  1'b1, 1'b0},
		'{32'h0000_0000, 1'b1, 8'd0,  1'b0, 1'b0},
		'{32'h8000_0001, 1'b1, 8'd0,  1'b1, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value;
	logic        last;
	logic        strobe;
	logic [31:0] sorted_value;
	logic        final_res;
	logic        overflow;

	data_t   held_vals [0:MAX_ITEMS-1];
	int      held_count;
	bit      held_dropped;
	sorted_t expected_sorted [$];

	bit burst_mode;
	int mismatch_count;
	int items_sent;
	int sets_sent;
	int overflow_sets;
	int results_checked;

	integer_sorter_top #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.last        (last),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.final_res   (final_res),
		.overflow    (overflow)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input data_t got, input data_t want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic void queue_expected(input sorted_t s);
		expected_sorted = {expected_sorted, s};
	endfunction

	// sorted insert on arrival unless full; on last, queue the whole store if keep
	function automatic void model_item(input data_t v, input logic l, input bit keep);
		int i;
		if (held_count < MAX_ITEMS) begin
			i = held_count;
			while (i > 0 && held_vals[i-1] > v) begin
				held_vals[i] = held_vals[i-1];
				i--;
			end
			held_vals[i] = v;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (l) begin
			if (keep) begin
				for (i = 0; i < held_count; i++)
					queue_expected(sorted_t'{held_vals[i], logic'(i == held_count - 1),
						logic'(held_dropped)});
			end
			if (held_dropped)
				overflow_sets++;
			sets_sent++;
			held_count = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic data_t pick_value(input val_style_t style);
		case (style)
			VAL_WIDE: return data_t'($urandom);
			VAL_CLUSTER: return data_t'($urandom_range(0, 8)) - 4;
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0000_0001;
					default: return data_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge that takes the item
	task automatic send_item(input data_t v, input logic l, input bit keep);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last  <= l;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		model_item(v, l, keep);
	endtask

	always @(posedge clk) begin : result_check
		sorted_t want;
		if (arst_n && strobe) begin
			if (expected_sorted.size() == 0) begin
				report_mismatch("result with nothing expected", data_t'(sorted_value), '0);
			end else begin
				want = expected_sorted.pop_front();
				results_checked++;
				if (sorted_value !== want.val)
					report_mismatch("sorted_value", data_t'(sorted_value), want.val);
				if (final_res !== want.fin)
					report_mismatch("final_res", data_t'(final_res), data_t'(want.fin));
				if (overflow !== want.ovf)
					report_mismatch("overflow", data_t'(overflow), data_t'(want.ovf));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int         r;
		int         k;
		int         set_size;
		int         rand_items;
		val_style_t style;
		dir_row_t   row;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last = 1'b0;
		held_count = 0;
		held_dropped = 1'b0;
		burst_mode = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		sets_sent = 0;
		overflow_sets = 0;
		results_checked = 0;
		rand_items = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS_N; r++) begin
			row = DIR_ROWS[r];
			burst_mode = (r % 4 == 3);
			for (k = 0; k < row.fill; k++)
				send_item(pick_value(VAL_WIDE), 1'b0, 1'b1);
			send_item(row.value, row.last, !row.typed);
			if (row.typed)
				queue_expected(sorted_t'{row.value, 1'b1, row.exp_ovf});
		end

		while (rand_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				set_size = $urandom_range(1, 8);
			else if (r < 88)
				set_size = $urandom_range(9, 40);
			else if (r < 96)
				set_size = $urandom_range(41, MAX_ITEMS);
			else
				set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
			if (set_size > RANDOM_ITEMS - rand_items)
				set_size = RANDOM_ITEMS - rand_items;
			style = val_style_t'($urandom_range(0, 2));
			burst_mode = ($urandom_range(0, 3) == 0);
			for (k = 0; k < set_size; k++)
				send_item(pick_value(style), logic'(k == set_size - 1), 1'b1);
			rand_items += set_size;
		end
		start <= 1'b0;

		while (expected_sorted.size() != 0)
			@(posedge clk);
		repeat (MAX_ITEMS + 16) @(posedge clk);

		$display("Sent %0d items in %0d sets, %0d of them overflowing the store.",
			items_sent, sets_sent, overflow_sets);
		$display("Checked %0d sorted results, %0d mismatches.", results_checked,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
